@@ src/sdbt_pkg.sv @@
// Shared types and constants for the sparse disk block translator.
// No dependencies; used by every module under src.
`default_nettype none

package sdbt_pkg;

    localparam int OFF_W     = 48;
    localparam int LEN_W     = 17;
    localparam int DEST_W    = 16;
    localparam int BS_W      = 29;
    localparam int CNT_W     = 13;
    localparam int MODE_W    = 2;
    localparam int ENTRY_W   = 32;
    localparam int IDX_W     = 12;
    localparam int BIDX_W    = 36;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 48;

    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 88;
    localparam int M_TUSER_W = 2;

    localparam logic [LEN_W-1:0]   MAX_READ     = 17'd65536;
    localparam logic [BS_W-1:0]    MIN_BLOCK    = 29'd4096;
    localparam logic [BS_W-1:0]    BS_RESET     = 29'd2097152;
    localparam logic [ENTRY_W-1:0] UNALLOCATED  = 32'hFFFF_FFFF;
    localparam logic [OFF_W-1:0]   SECTOR_BYTES = 48'd512;
    localparam int                 SECTOR_SHIFT = 9;

    localparam logic [MODE_W-1:0] MODE_NONE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FIXED   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DYNAMIC = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VSIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BSIZE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ECOUNT = 2'd3;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK,
        S_DIV,
        S_LOOK,
        S_CALC,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

@@ src/sdbt_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Uses sdbt_pkg for widths.
`default_nettype none

module sdbt_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [sdbt_pkg::OFF_W-1:0] i_dividend,
    input  wire logic [sdbt_pkg::BS_W-1:0]  i_divisor,
    output logic                             o_done,
    output logic [sdbt_pkg::OFF_W-1:0]      o_quot,
    output logic [sdbt_pkg::BS_W-1:0]       o_rem
);

    localparam int STEPS = sdbt_pkg::OFF_W;
    localparam int CW    = $clog2(STEPS);

    logic                       r_busy;
    logic                       r_done;
    logic [CW-1:0]              r_cnt;
    logic [sdbt_pkg::OFF_W-1:0] r_quo;
    logic [sdbt_pkg::BS_W-1:0]  r_rem;
    logic [sdbt_pkg::BS_W-1:0]  r_dvs;

    logic [sdbt_pkg::BS_W:0]    n_trial;
    logic [sdbt_pkg::BS_W:0]    n_diff;
    logic                       n_ge;

    always_comb begin
        n_trial = {r_rem, r_quo[sdbt_pkg::OFF_W-1]};
        n_diff  = n_trial - {1'b0, r_dvs};
        n_ge    = n_trial >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[sdbt_pkg::OFF_W-2:0], n_ge};
            r_rem <= n_ge ? n_diff[sdbt_pkg::BS_W-1:0] : n_trial[sdbt_pkg::BS_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

@@ src/sdbt_bat.sv @@
// Block allocation table storage: one write port, one registered read port.
// Uses sdbt_pkg for the entry width.
`default_nettype none

module sdbt_bat #(
    parameter int DEPTH = 4096
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [$clog2(DEPTH)-1:0]      i_waddr,
    input  wire logic [sdbt_pkg::ENTRY_W-1:0] i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]      i_raddr,
    output logic [sdbt_pkg::ENTRY_W-1:0]      o_rdata
);

    logic [sdbt_pkg::ENTRY_W-1:0] r_mem [DEPTH];
    logic [sdbt_pkg::ENTRY_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

@@ src/sparse_disk_block_translator_top.sv @@
// Sparse disk block translator: turns virtual disk read requests into image read chunks
// through a loadable block allocation table. A table load is written in the idle state and
// leaves the input ready. A read request passes a check state, then the bit-serial divider that
// splits the start offset into block index and offset within block, then a lookup, a calc and
// an output state per chunk, where the output may stall; a read yields 1 to 17 chunks. Rejected,
// fixed-mode and empty reads skip the divider and go from the check state to the output state.
// The input is ready only while no request is in progress. Table entries that were never
// loaded read back as undefined data. Depends on sdbt_pkg, sdbt_div and sdbt_bat.
`default_nettype none

module sparse_disk_block_translator_top #(
    parameter int BAT_DEPTH = 4096
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // tdata: entry_index[11:0], entry_value[43:12], offset[91:44], read_length[108:92]
    input  wire logic [sdbt_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // tuser: func[0]
    input  wire logic                              i_s_tuser,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // tdata: source_offset[47:0], chunk_length[64:48], dest_position[80:65]
    output logic [sdbt_pkg::M_TDATA_W-1:0]        o_m_tdata,
    // tuser: zero_fill[0], status[1]
    output logic [sdbt_pkg::M_TUSER_W-1:0]        o_m_tuser,
    output logic                                   o_m_tlast,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    input  wire logic                              i_cfg_we,
    input  wire logic [sdbt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [sdbt_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int AW = $clog2(BAT_DEPTH);

    // config registers
    logic [sdbt_pkg::MODE_W-1:0] r_mode;
    logic [sdbt_pkg::OFF_W-1:0]  r_vsize;
    logic [sdbt_pkg::BS_W-1:0]   r_bsize;
    logic [sdbt_pkg::CNT_W-1:0]  r_ecount;

    sdbt_pkg::t_state r_state, n_state;

    logic [sdbt_pkg::OFF_W-1:0]  r_off;
    logic [sdbt_pkg::LEN_W-1:0]  r_len;
    logic [sdbt_pkg::LEN_W-1:0]  r_done;
    logic [sdbt_pkg::BIDX_W-1:0] r_bidx;
    logic [sdbt_pkg::BS_W-1:0]   r_boff;
    logic                        r_inrng;

    logic [sdbt_pkg::OFF_W-1:0]  r_src;
    logic [sdbt_pkg::LEN_W-1:0]  r_clen;
    logic [sdbt_pkg::DEST_W-1:0] r_dest;
    logic                        r_zf;
    logic                        r_st;
    logic                        r_last;

    logic                          in_acc;
    logic [sdbt_pkg::IDX_W-1:0]    in_idx;
    logic [sdbt_pkg::ENTRY_W-1:0]  in_val;
    logic [sdbt_pkg::OFF_W-1:0]    in_off;
    logic [sdbt_pkg::LEN_W-1:0]    in_len;

    logic                          reject;
    logic                          is_fixed;
    logic [sdbt_pkg::OFF_W-1:0]    room_left;
    logic [sdbt_pkg::BS_W-1:0]     bs_eff;
    logic [sdbt_pkg::BIDX_W-1:0]   limit;
    logic                          bidx_ok;
    logic [sdbt_pkg::LEN_W-1:0]    rem_len;
    logic [sdbt_pkg::BS_W-1:0]     blk_room;
    logic                          is_last;
    logic [sdbt_pkg::LEN_W-1:0]    chunk;
    logic                          zf;
    logic [sdbt_pkg::OFF_W-1:0]    src;

    logic                          div_start;
    logic                          div_done;
    logic [sdbt_pkg::OFF_W-1:0]    div_q;
    logic [sdbt_pkg::BS_W-1:0]     div_r;

    logic                          bat_we;
    logic [sdbt_pkg::ENTRY_W-1:0]  bat_q;

    function automatic logic [sdbt_pkg::BIDX_W-1:0] BIDX_W_EXT(
        input logic [sdbt_pkg::CNT_W-1:0] v
    );
        return sdbt_pkg::BIDX_W'(v);
    endfunction

    assign in_acc = i_s_tvalid && o_s_tready;
    assign in_idx = i_s_tdata[11:0];
    assign in_val = i_s_tdata[43:12];
    assign in_off = i_s_tdata[91:44];
    assign in_len = i_s_tdata[108:92];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= sdbt_pkg::MODE_NONE;
            r_vsize  <= '0;
            r_bsize  <= sdbt_pkg::BS_RESET;
            r_ecount <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sdbt_pkg::CFG_MODE:   r_mode   <= i_cfg_data[sdbt_pkg::MODE_W-1:0];
                sdbt_pkg::CFG_VSIZE:  r_vsize  <= i_cfg_data[sdbt_pkg::OFF_W-1:0];
                sdbt_pkg::CFG_BSIZE:  r_bsize  <= i_cfg_data[sdbt_pkg::BS_W-1:0];
                sdbt_pkg::CFG_ECOUNT: r_ecount <= i_cfg_data[sdbt_pkg::CNT_W-1:0];
            endcase
        end
    end

    always_comb begin
        reject    = (r_mode != sdbt_pkg::MODE_FIXED && r_mode != sdbt_pkg::MODE_DYNAMIC)
                    || (r_off >= r_vsize);
        is_fixed  = r_mode == sdbt_pkg::MODE_FIXED;
        room_left = r_vsize - r_off;
        bs_eff    = (r_bsize < sdbt_pkg::MIN_BLOCK) ? sdbt_pkg::MIN_BLOCK : r_bsize;
        limit     = (BIDX_W_EXT(r_ecount) > sdbt_pkg::BIDX_W'(BAT_DEPTH))
                    ? sdbt_pkg::BIDX_W'(BAT_DEPTH) : BIDX_W_EXT(r_ecount);
        bidx_ok   = r_bidx < limit;
        rem_len   = r_len - r_done;
        blk_room  = bs_eff - r_boff;
        is_last   = sdbt_pkg::BS_W'(rem_len) <= blk_room;
        chunk     = is_last ? rem_len : blk_room[sdbt_pkg::LEN_W-1:0];
        zf        = !r_inrng || (bat_q == sdbt_pkg::UNALLOCATED);
        src       = (sdbt_pkg::OFF_W'(bat_q) << sdbt_pkg::SECTOR_SHIFT)
                    + sdbt_pkg::SECTOR_BYTES + sdbt_pkg::OFF_W'(r_boff);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sdbt_pkg::S_IDLE:
                if (in_acc && i_s_tuser == sdbt_pkg::FUNC_READ) begin
                    n_state = sdbt_pkg::S_CHK;
                end
            sdbt_pkg::S_CHK:
                if (reject || is_fixed || r_len == '0) begin
                    n_state = sdbt_pkg::S_OUT;
                end else begin
                    n_state = sdbt_pkg::S_DIV;
                end
            sdbt_pkg::S_DIV:
                if (div_done) begin
                    n_state = sdbt_pkg::S_LOOK;
                end
            sdbt_pkg::S_LOOK:
                n_state = sdbt_pkg::S_CALC;
            sdbt_pkg::S_CALC:
                n_state = sdbt_pkg::S_OUT;
            sdbt_pkg::S_OUT:
                if (i_m_tready) begin
                    n_state = r_last ? sdbt_pkg::S_IDLE : sdbt_pkg::S_LOOK;
                end
        endcase
    end

    // state outputs
    always_comb begin
        o_s_tready = r_state == sdbt_pkg::S_IDLE;
        o_m_tvalid = r_state == sdbt_pkg::S_OUT;
        div_start  = (r_state == sdbt_pkg::S_CHK) && !reject && !is_fixed && (r_len != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdbt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            sdbt_pkg::S_IDLE: begin
                if (in_acc) begin
                    r_off <= in_off;
                    r_len <= (in_len > sdbt_pkg::MAX_READ) ? sdbt_pkg::MAX_READ : in_len;
                end
            end
            sdbt_pkg::S_CHK: begin
                r_done <= '0;
                r_dest <= '0;
                r_zf   <= 1'b0;
                r_st   <= reject;
                r_last <= 1'b1;
                if (!reject && is_fixed) begin
                    r_src  <= (r_len != '0) ? r_off : '0;
                    r_clen <= r_len;
                end else begin
                    r_src  <= '0;
                    r_clen <= '0;
                end
                if (!reject && !is_fixed && (sdbt_pkg::OFF_W'(r_len) > room_left)) begin
                    r_len <= room_left[sdbt_pkg::LEN_W-1:0];
                end
            end
            sdbt_pkg::S_DIV: begin
                if (div_done) begin
                    r_bidx <= div_q[sdbt_pkg::BIDX_W-1:0];
                    r_boff <= div_r;
                end
            end
            sdbt_pkg::S_LOOK: begin
                r_inrng <= bidx_ok;
            end
            sdbt_pkg::S_CALC: begin
                r_src  <= zf ? '0 : src;
                r_clen <= chunk;
                r_dest <= r_done[sdbt_pkg::DEST_W-1:0];
                r_zf   <= zf;
                r_st   <= 1'b0;
                r_last <= is_last;
                r_done <= r_done + chunk;
                r_bidx <= r_bidx + 1'b1;
                r_boff <= '0;
            end
            sdbt_pkg::S_OUT: begin
            end
        endcase
    end

    assign bat_we = in_acc && (i_s_tuser == sdbt_pkg::FUNC_LOAD)
                    && (32'(in_idx) < 32'(BAT_DEPTH));

    sdbt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_off),
        .i_divisor  (bs_eff),
        .o_done     (div_done),
        .o_quot     (div_q),
        .o_rem      (div_r)
    );

    sdbt_bat #(
        .DEPTH (BAT_DEPTH)
    ) u_bat (
        .i_clk   (i_clk),
        .i_we    (bat_we),
        .i_waddr (AW'(in_idx)),
        .i_wdata (in_val),
        .i_raddr (AW'(r_bidx)),
        .o_rdata (bat_q)
    );

    assign o_m_tdata = {7'd0, r_dest, r_clen, r_src};
    assign o_m_tuser = {r_st, r_zf};
    assign o_m_tlast = r_last;

    a_zero_fill_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && r_zf |-> r_src == '0)
        else $error("zero-fill chunk with nonzero source offset");

    a_reject_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && r_st |-> r_last && r_clen == '0 && !r_zf)
        else $error("rejected result is not a single empty last result");

    a_last_matches_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !r_st |->
            (r_last == ((sdbt_pkg::LEN_W'(r_dest) + r_clen) == r_len)))
        else $error("last flag disagrees with chunk coverage of the request");

    a_mid_chunk_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !r_last |-> r_clen != '0)
        else $error("empty chunk before the end of a request");

    a_no_accept_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> !o_s_tready)
        else $error("input ready while a division is in progress");

endmodule

`default_nettype wire
